[hdl/kai_pkg.sv]
// Package for the keyframe automation interpolator.
// Shared constants, types and the sequencer state encoding. No dependencies.
package kai_pkg;

   localparam int KEYS_DEFAULT      = 16;
   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int OP_W    = 2;
   localparam int DELAY_W = 24;
   localparam int VAL_W   = 32;
   localparam int MODE_W  = 2;
   localparam int TIME_W  = 32;

   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_SET    = 2'd2;

   localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GAP    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STEP   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CUBIC  = 2'd3;

   // Width of the wide signed working registers of the arithmetic unit.
   localparam int ACC_W = 96;

   typedef enum logic [15:0] {
      ST_IDLE   = 16'h0001,
      ST_INS    = 16'h0002,
      ST_SCAN   = 16'h0004,
      ST_RD     = 16'h0008,
      ST_DIVI   = 16'h0010,
      ST_DIV    = 16'h0020,
      ST_EVAL   = 16'h0040,
      ST_MUL    = 16'h0080,
      ST_MULW   = 16'h0100,
      ST_PRUNE  = 16'h0200,
      ST_DONE   = 16'h0400,
      ST_OUT    = 16'h0800,
      ST_SHIFTI = 16'h1000,
      ST_INSW   = 16'h2000,
      ST_RD2    = 16'h4000,
      ST_RD3    = 16'h8000
   } state_type;

   // Command to the key store.
   typedef struct packed {
      logic shift_up;    // raise count by one (the sequencer moves entries [pos..count-1] up and writes at pos)
      logic shift_down;  // lower count by one (the sequencer drops entry 0 by moving entries down)
   } store_cmd_type;

endpackage

[hdl/keyframe_automation_interpolator.sv]
// Keyframe automation interpolator: top level with sequencer.
// Depends on kai_pkg, kai_store, kai_div and kai_mac.
//
// One request carries op, delay_samples, value and mode; one response carries
// level, active and status. The block holds one request at a time: req_tready
// is high only when idle. An insert scans the sorted store and shifts later keys
// up. A tick scans the store for the first key at or after the sample time,
// fetches up to four neighbor values, runs a serial divider for the fraction,
// then evaluates the segment (with a shared multiplier for linear and cubic,
// in three passes for cubic), and drops the oldest key by shifting the store
// down when three or more keys lie in the past. The response stays registered
// until rsp_tready takes it.
module keyframe_automation_interpolator #(
   parameter int KEYS      = kai_pkg::KEYS_DEFAULT,
   parameter int FRAC_BITS = kai_pkg::FRAC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // op[1:0], delay_samples[25:2], value[57:26], mode[59:58]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // level[31:0], active[32], status[33]
);
   localparam int IDX_W  = $clog2(KEYS);
   localparam int NUM_W  = kai_pkg::TIME_W + FRAC_BITS;
   localparam int ACC_W  = kai_pkg::ACC_W;
   // ceil(0.9999 * ONE)
   localparam longint THRESH_L = ((longint'(1) << FRAC_BITS) * 9999 + 9999) / 10000;
   localparam logic [FRAC_BITS:0] STEP_THRESH = (FRAC_BITS+1)'(THRESH_L);

   kai_pkg::state_type state_ff, state_in;

   // captured request
   logic [kai_pkg::OP_W-1:0]          op_ff, op_in;
   logic [kai_pkg::TIME_W-1:0]        tkey_ff, tkey_in;
   logic signed [kai_pkg::VAL_W-1:0]  val_ff, val_in;
   logic [kai_pkg::MODE_W-1:0]        mode_ff, mode_in;

   logic [kai_pkg::TIME_W-1:0]        clk_ff, clk_in;
   logic signed [kai_pkg::VAL_W-1:0]  held_ff, held_in;

   // scan / mover pointer
   logic [IDX_W:0] ptr_ff, ptr_in;
   logic [IDX_W:0] pos_ff, pos_in;
   logic [1:0]     rdc_ff, rdc_in;   // neighbor fetch counter

   // segment operands
   logic [kai_pkg::TIME_W-1:0]        tp_ff, tp_in, tc_ff, tc_in;
   logic signed [kai_pkg::VAL_W-1:0]  p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in, p3_ff, p3_in;
   logic [kai_pkg::MODE_W-1:0]        cmode_ff, cmode_in;
   logic [FRAC_BITS:0]                f_ff, f_in;
   logic [1:0]                        pass_ff, pass_in;
   logic signed [ACC_W-1:0]           acc_ff, acc_in;

   logic        active_ff, active_in, status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_level_ff, rsp_level_in;
   logic        rsp_active_ff, rsp_active_in, rsp_status_ff, rsp_status_in;

   // store signals
   logic [IDX_W-1:0]                 rd_addr;
   logic [kai_pkg::TIME_W-1:0]       rd_time;
   logic signed [kai_pkg::VAL_W-1:0] rd_value;
   logic [kai_pkg::MODE_W-1:0]       rd_mode;
   logic                             wr_en;
   logic [IDX_W-1:0]                 wr_addr;
   logic [kai_pkg::TIME_W-1:0]       wr_time;
   logic signed [kai_pkg::VAL_W-1:0] wr_value;
   logic [kai_pkg::MODE_W-1:0]       wr_mode;
   kai_pkg::store_cmd_type           cmd;
   logic [IDX_W:0]                   count;

   // divider
   logic              div_start, div_done;
   logic [NUM_W-1:0]  div_num, div_quo;
   logic [31:0]       den;

   // mac
   logic signed [ACC_W-1:0] mac_x, mac_c, mac_q;

   logic signed [ACC_W-1:0] ca, cb, cc, lin_x, sat_src;
   logic signed [31:0]      sat_out;

   kai_store #(.KEYS(KEYS), .IDX_W(IDX_W)) u_store (
      .clock, .reset, .rd_addr, .rd_time, .rd_value, .rd_mode,
      .wr_en, .wr_addr, .wr_time, .wr_value, .wr_mode, .cmd, .count
   );

   kai_div #(.NUM_W(NUM_W), .DEN_W(32)) u_div (
      .clock, .reset, .start(div_start), .num(div_num), .den,
      .done(div_done), .quo(div_quo)
   );

   kai_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock, .x(mac_x), .f(f_ff), .c(mac_c), .q(mac_q)
   );

   assign den     = tc_ff - tp_ff;
   assign div_num = {clk_ff - tp_ff, {FRAC_BITS{1'b0}}};

   // cubic coefficients
   always_comb begin
      ca = -ACC_W'(p0_ff) + 3 * ACC_W'(p1_ff) - 3 * ACC_W'(p2_ff) + ACC_W'(p3_ff);
      cb = 2 * ACC_W'(p0_ff) - 5 * ACC_W'(p1_ff) + 4 * ACC_W'(p2_ff) - ACC_W'(p3_ff);
      cc = ACC_W'(p2_ff) - ACC_W'(p0_ff);
      // linear: vp + floor((vc-vp)*f/ONE) equals floor((vp*(ONE-f)+vc*f)/ONE)
      lin_x = ACC_W'(p2_ff) - ACC_W'(p1_ff);
   end

   always_comb begin
      if (sat_src > ACC_W'(64'sh7FFFFFFF)) begin
         sat_out = 32'sh7FFFFFFF;
      end else if (sat_src < -ACC_W'(64'sh80000000)) begin
         sat_out = 32'sh80000000;
      end else begin
         sat_out = sat_src[31:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      tkey_in   = tkey_ff;
      val_in    = val_ff;
      mode_in   = mode_ff;
      clk_in    = clk_ff;
      held_in   = held_ff;
      ptr_in    = ptr_ff;
      pos_in    = pos_ff;
      rdc_in    = rdc_ff;
      tp_in     = tp_ff;
      tc_in     = tc_ff;
      p0_in     = p0_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      p3_in     = p3_ff;
      cmode_in  = cmode_ff;
      f_in      = f_ff;
      pass_in   = pass_ff;
      acc_in    = acc_ff;
      active_in = active_ff;
      status_in = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_active_in = rsp_active_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr   = ptr_ff[IDX_W-1:0];
      wr_en     = 1'b0;
      wr_addr   = ptr_ff[IDX_W-1:0];
      wr_time   = rd_time;
      wr_value  = rd_value;
      wr_mode   = rd_mode;
      cmd       = '0;
      div_start = 1'b0;
      mac_x     = '0;
      mac_c     = '0;
      sat_src   = acc_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         kai_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tdata[1:0];
               tkey_in   = clk_ff + 32'(req_tdata[25:2]);
               val_in    = req_tdata[57:26];
               mode_in   = req_tdata[59:58];
               active_in = 1'b0;
               status_in = 1'b0;
               ptr_in    = '0;
               case (req_tdata[1:0])
                  kai_pkg::OP_TICK: begin
                     state_in = kai_pkg::ST_SCAN;
                  end
                  kai_pkg::OP_INSERT: begin
                     if (count == (IDX_W+1)'(KEYS)) begin
                        status_in = 1'b1;
                        state_in  = kai_pkg::ST_DONE;
                     end else begin
                        state_in = kai_pkg::ST_INS;
                     end
                  end
                  kai_pkg::OP_SET: begin
                     held_in  = req_tdata[57:26];
                     state_in = kai_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = kai_pkg::ST_DONE;
                  end
               endcase
            end
         end

         // insert: find first entry with time >= key time
         kai_pkg::ST_INS: begin
            // read issued for ptr; the registered data arrives in ST_INSW
            state_in = kai_pkg::ST_INSW;
         end
         kai_pkg::ST_INSW: begin
            if (ptr_ff < count && rd_time < tkey_ff) begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = kai_pkg::ST_INS;
            end else begin
               pos_in   = ptr_ff;
               ptr_in   = count;
               state_in = kai_pkg::ST_SHIFTI;
            end
         end
         // shift up: read ptr-1, write ptr, descending
         kai_pkg::ST_SHIFTI: begin
            if (ptr_ff == pos_ff) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[IDX_W-1:0];
               wr_time  = tkey_ff;
               wr_value = val_ff;
               wr_mode  = mode_ff;
               cmd.shift_up = 1'b1;
               state_in = kai_pkg::ST_DONE;
            end else begin
               rd_addr  = IDX_W'(ptr_ff - 1'b1);
               state_in = kai_pkg::ST_MULW;  // registered read, then write in ST_MULW
            end
         end
         kai_pkg::ST_MULW: begin
            // shared move step: insert writes ptr from ptr-1, prune writes ptr from ptr+1
            wr_en   = 1'b1;
            wr_addr = ptr_ff[IDX_W-1:0];
            if (op_ff == kai_pkg::OP_INSERT) begin
               ptr_in   = ptr_ff - 1'b1;
               state_in = kai_pkg::ST_SHIFTI;
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = kai_pkg::ST_PRUNE;
            end
         end

         // tick: scan for first key at or after now
         kai_pkg::ST_SCAN: begin
            state_in = kai_pkg::ST_RD;
         end
         kai_pkg::ST_RD: begin
            if (ptr_ff < count && rd_time < clk_ff) begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = kai_pkg::ST_SCAN;
            end else begin
               pos_in = ptr_ff;
               if (ptr_ff >= (IDX_W+1)'(1) && ptr_ff < count) begin
                  active_in = 1'b1;
                  tc_in     = rd_time;
                  p2_in     = rd_value;
                  p3_in     = rd_value;
                  cmode_in  = rd_mode;
                  rdc_in    = 2'd0;
                  rd_addr   = IDX_W'(ptr_ff - 1'b1);
                  state_in  = kai_pkg::ST_RD2;
               end else begin
                  state_in = kai_pkg::ST_EVAL;
               end
            end
         end
         // neighbor fetch: rdc 0 -> prev data arriving, 1 -> i-2, 2 -> i+1
         kai_pkg::ST_RD2: begin
            case (rdc_ff)
               2'd0: begin
                  tp_in  = rd_time;
                  p1_in  = rd_value;
                  p0_in  = rd_value;
                  rd_addr = IDX_W'(pos_ff - 2'd2);
                  rdc_in = 2'd1;
               end
               2'd1: begin
                  if (pos_ff >= (IDX_W+1)'(2)) begin
                     p0_in = rd_value;
                  end
                  rd_addr = IDX_W'(pos_ff + 1'b1);
                  rdc_in  = 2'd2;
               end
               default: begin
                  if (pos_ff + 1'b1 < count) begin
                     p3_in = rd_value;
                  end
                  state_in = kai_pkg::ST_RD3;
               end
            endcase
         end
         kai_pkg::ST_RD3: begin
            if (den == 32'd0) begin
               f_in     = '0;
               state_in = kai_pkg::ST_EVAL;
            end else begin
               div_start = 1'b1;
               state_in  = kai_pkg::ST_DIV;
            end
         end
         kai_pkg::ST_DIV: begin
            if (div_done) begin
               f_in     = div_quo[FRAC_BITS:0];
               state_in = kai_pkg::ST_EVAL;
            end
         end
         kai_pkg::ST_EVAL: begin
            pass_in = 2'd0;
            if (!active_ff) begin
               state_in = kai_pkg::ST_PRUNE;
               ptr_in   = '0;
            end else begin
               case (cmode_ff)
                  kai_pkg::MODE_GAP: begin
                     held_in  = '0;
                     ptr_in   = '0;
                     state_in = kai_pkg::ST_PRUNE;
                  end
                  kai_pkg::MODE_STEP: begin
                     held_in  = (f_ff >= STEP_THRESH) ? p2_ff : p1_ff;
                     ptr_in   = '0;
                     state_in = kai_pkg::ST_PRUNE;
                  end
                  default: begin
                     state_in = kai_pkg::ST_MUL;
                  end
               endcase
            end
         end
         kai_pkg::ST_MUL: begin
            // issue one mac pass; result lands next cycle in ST_OUT
            if (cmode_ff == kai_pkg::MODE_LINEAR) begin
               mac_x = lin_x;
               mac_c = ACC_W'(p1_ff);
            end else begin
               case (pass_ff)
                  2'd0: begin
                     mac_x = ca;
                     mac_c = cb;
                  end
                  2'd1: begin
                     mac_x = acc_ff;
                     mac_c = cc;
                  end
                  default: begin
                     mac_x = acc_ff;
                     mac_c = 2 * ACC_W'(p1_ff);
                  end
               endcase
            end
            state_in = kai_pkg::ST_OUT;
         end
         kai_pkg::ST_OUT: begin
            acc_in = mac_q;
            if (cmode_ff == kai_pkg::MODE_LINEAR) begin
               sat_src  = mac_q;
               held_in  = sat_out;
               ptr_in   = '0;
               state_in = kai_pkg::ST_PRUNE;
            end else if (pass_ff == 2'd2) begin
               sat_src  = mac_q >>> 1;
               held_in  = sat_out;
               ptr_in   = '0;
               state_in = kai_pkg::ST_PRUNE;
            end else begin
               pass_in  = pass_ff + 1'b1;
               state_in = kai_pkg::ST_MUL;
            end
         end

         // prune: if three or more keys lie before now, move entries down by one
         kai_pkg::ST_PRUNE: begin
            if (pos_ff < (IDX_W+1)'(3)) begin
               clk_in   = clk_ff + 1'b1;
               state_in = kai_pkg::ST_DONE;
            end else if (ptr_ff + 1'b1 < count) begin
               rd_addr  = IDX_W'(ptr_ff + 1'b1);
               state_in = kai_pkg::ST_MULW;
            end else begin
               cmd.shift_down = 1'b1;
               clk_in   = clk_ff + 1'b1;
               state_in = kai_pkg::ST_DONE;
            end
         end

         kai_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_level_in  = held_ff;
               rsp_active_in = active_ff && (op_ff == kai_pkg::OP_TICK);
               rsp_status_in = status_ff;
               state_in      = kai_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kai_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kai_pkg::ST_IDLE;
         clk_ff       <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         status_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clk_ff       <= clk_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         status_ff    <= status_in;
      end
      op_ff    <= op_in;
      tkey_ff  <= tkey_in;
      val_ff   <= val_in;
      mode_ff  <= mode_in;
      ptr_ff   <= ptr_in;
      pos_ff   <= pos_in;
      rdc_ff   <= rdc_in;
      tp_ff    <= tp_in;
      tc_ff    <= tc_in;
      p0_ff    <= p0_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      p3_ff    <= p3_in;
      cmode_ff <= cmode_in;
      f_ff     <= f_in;
      pass_ff  <= pass_in;
      acc_ff   <= acc_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_active_ff <= rsp_active_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_tready = (state_ff == kai_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_active_ff, rsp_level_ff};
endmodule

[hdl/kai_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// No dependencies; widths are passed as parameters.
module kai_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = busy_ff && (cnt_ff == CNT_W'(1));
   assign quo  = quo_in;
endmodule

[hdl/kai_store.sv]
// Sorted keyframe store: time, value and mode memories, entries moved one at a time.
// Depends on kai_pkg.
module kai_store #(
   parameter int KEYS  = kai_pkg::KEYS_DEFAULT,
   parameter int IDX_W = $clog2(KEYS)
) (
   input  logic                            clock,
   input  logic                            reset,
   // read port used by scans and by the mover
   input  logic [IDX_W-1:0]                rd_addr,
   output logic [kai_pkg::TIME_W-1:0]      rd_time,
   output logic signed [kai_pkg::VAL_W-1:0] rd_value,
   output logic [kai_pkg::MODE_W-1:0]      rd_mode,
   // write port
   input  logic                            wr_en,
   input  logic [IDX_W-1:0]                wr_addr,
   input  logic [kai_pkg::TIME_W-1:0]      wr_time,
   input  logic signed [kai_pkg::VAL_W-1:0] wr_value,
   input  logic [kai_pkg::MODE_W-1:0]      wr_mode,
   // fill count
   input  kai_pkg::store_cmd_type          cmd,
   output logic [IDX_W:0]                  count
);
   logic [kai_pkg::TIME_W-1:0]       time_mem  [KEYS];
   logic signed [kai_pkg::VAL_W-1:0] value_mem [KEYS];
   logic [kai_pkg::MODE_W-1:0]       mode_mem  [KEYS];
   logic [IDX_W:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr]  <= wr_time;
         value_mem[wr_addr] <= wr_value;
         mode_mem[wr_addr]  <= wr_mode;
      end
      rd_time  <= time_mem[rd_addr];
      rd_value <= value_mem[rd_addr];
      rd_mode  <= mode_mem[rd_addr];
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.shift_up) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.shift_down) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;
endmodule

[hdl/kai_mac.sv]
// Shared multiply-accumulate step: q = floor(x*f / 2^FRAC_BITS) + c, one per cycle, registered.
// Depends on kai_pkg.
module kai_mac #(
   parameter int FRAC_BITS = kai_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic signed [kai_pkg::ACC_W-1:0]   x,
   input  logic [FRAC_BITS:0]                 f,
   input  logic signed [kai_pkg::ACC_W-1:0]   c,
   output logic signed [kai_pkg::ACC_W-1:0]   q
);
   // x stays within about 37 bits, f within FRAC_BITS+1: one narrow product.
   localparam int XN = 40;
   logic signed [XN-1:0]              xn;
   logic signed [XN+FRAC_BITS+1:0]    prod;
   logic signed [kai_pkg::ACC_W-1:0]  q_ff;

   always_comb begin
      xn   = x[XN-1:0];
      prod = xn * $signed({1'b0, f});
   end

   always_ff @(posedge clock) begin
      q_ff <= kai_pkg::ACC_W'(prod >>> FRAC_BITS) + c;
   end

   assign q = q_ff;
endmodule
